@@ src/assert_macros.svh @@
// Assertion macros for the RTL of the hash map block.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPHM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LPHM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/lphm_pkg.sv @@
// Package for the linear probing hash map: widths, status codes, shared structs.
// No dependencies.
`timescale 1ns / 1ps

package lphm_pkg;

	localparam int SLOT_BITS_DEF = 13;
	localparam int KEY_W         = 32;
	localparam int VAL_W         = 8;
	localparam int STATUS_W      = 3;
	localparam int FILL_W        = 14;

	localparam logic [FILL_W-1:0] FILL_MAX = '1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_MISSING  = 3'd4,
		ST_ZERO     = 3'd5
	} status_t;

	// write enables from the sequencer to the slot store
	typedef struct packed {
		logic key_we;
		logic val_we;
	} mem_ctl_t;

	// one finished result word
	typedef struct packed {
		status_t           status;
		logic [VAL_W-1:0]  found_value;
		logic [FILL_W-1:0] fill_count;
	} res_t;

endpackage

@@ src/lphm_stream_if.sv @@
// Request and response channel interfaces of the hash map block.
// Depends on lphm_pkg for field widths.
`timescale 1ns / 1ps

interface lphm_req_if;
	logic                      valid;
	logic                      ready;
	logic                      op;
	logic [lphm_pkg::KEY_W-1:0] key;
	logic [lphm_pkg::VAL_W-1:0] value;

	modport source (output valid, op, key, value, input ready);
	modport sink   (input valid, op, key, value, output ready);
endinterface

interface lphm_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lphm_pkg::STATUS_W-1:0] status;
	logic [lphm_pkg::VAL_W-1:0]    found_value;
	logic [lphm_pkg::FILL_W-1:0]   fill_count;

	modport source (output valid, status, found_value, fill_count, input ready);
	modport sink   (input valid, status, found_value, fill_count, output ready);
endinterface

@@ src/lphm_slot_mem.sv @@
// Slot store: key array and value array, one write and one registered read port each.
// Depends on lphm_pkg.
`timescale 1ns / 1ps

module lphm_slot_mem #(
	parameter int SLOT_BITS = lphm_pkg::SLOT_BITS_DEF
) (
	input  logic                       clk,
	input  lphm_pkg::mem_ctl_t         ctl,
	input  logic [SLOT_BITS-1:0]       waddr,
	input  logic [SLOT_BITS-1:0]       raddr,
	input  logic [lphm_pkg::KEY_W-1:0] wkey,
	input  logic [lphm_pkg::VAL_W-1:0] wval,
	output logic [lphm_pkg::KEY_W-1:0] rkey,
	output logic [lphm_pkg::VAL_W-1:0] rval
);

	localparam int DEPTH = 1 << SLOT_BITS;

	logic [lphm_pkg::KEY_W-1:0] key_mem [DEPTH];
	logic [lphm_pkg::VAL_W-1:0] val_mem [DEPTH];
	logic [lphm_pkg::KEY_W-1:0] rkey_q;
	logic [lphm_pkg::VAL_W-1:0] rval_q;

	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[waddr] <= wkey;
		end
		rkey_q <= key_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[waddr] <= wval;
		end
		rval_q <= val_mem[raddr];
	end

	assign rkey = rkey_q;
	assign rval = rval_q;

endmodule

@@ src/lphm_probe_fsm.sv @@
// Probe sequencer: clearing sweep, slot-by-slot probe with one shared key compare,
// fill counter. Depends on lphm_pkg.
`timescale 1ns / 1ps

module lphm_probe_fsm #(
	parameter int SLOT_BITS = lphm_pkg::SLOT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       req_op,
	input  logic [lphm_pkg::KEY_W-1:0] req_key,
	input  logic [lphm_pkg::VAL_W-1:0] req_value,
	output logic                       res_valid,
	input  logic                       res_take,
	output lphm_pkg::res_t             res,
	output lphm_pkg::mem_ctl_t         mem_ctl,
	output logic [SLOT_BITS-1:0]       waddr,
	output logic [SLOT_BITS-1:0]       raddr,
	output logic [lphm_pkg::KEY_W-1:0] wkey,
	output logic [lphm_pkg::VAL_W-1:0] wval,
	input  logic [lphm_pkg::KEY_W-1:0] rkey,
	input  logic [lphm_pkg::VAL_W-1:0] rval
);

	localparam int CNT_W = SLOT_BITS + 1;
	localparam int CMP_W = (CNT_W > lphm_pkg::FILL_W) ? CNT_W : lphm_pkg::FILL_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CHECK = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [SLOT_BITS-1:0]       clr_q;
	logic [SLOT_BITS-1:0]       addr_q;
	logic [SLOT_BITS-1:0]       n_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       op_q;
	logic [lphm_pkg::KEY_W-1:0] key_q;
	logic [lphm_pkg::VAL_W-1:0] val_q;
	lphm_pkg::status_t          status_q;
	logic [lphm_pkg::VAL_W-1:0] found_q;

	logic                       accept;
	logic                       hit_empty;
	logic                       hit_match;
	logic                       last_probe;
	logic [SLOT_BITS-1:0]       next_addr;
	logic                       do_insert;

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign hit_empty  = (rkey == '0);
	assign hit_match  = (rkey == key_q);
	assign last_probe = (n_q == '1);
	assign next_addr  = addr_q + SLOT_BITS'(1);
	assign do_insert  = (state_q == S_CHECK) && (op_q == lphm_pkg::OP_INSERT) && hit_empty;

	// read address runs one slot ahead so the next slot's key is ready as each probe finishes
	assign raddr = (state_q == S_IDLE) ? req_key[SLOT_BITS-1:0] : next_addr;

	always_comb begin
		mem_ctl.key_we = (state_q == S_CLEAR) || do_insert;
		mem_ctl.val_we = do_insert;
		waddr          = (state_q == S_CLEAR) ? clr_q : addr_q;
		wkey           = (state_q == S_CLEAR) ? '0 : key_q;
		wval           = val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_BITS'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					n_q <= '0;
					if (accept) begin
						state_q <= (req_key == '0) ? S_DONE : S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit_empty || hit_match || last_probe) begin
						state_q <= S_DONE;
					end else begin
						n_q <= n_q + SLOT_BITS'(1);
					end
					if (do_insert) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			op_q     <= req_op;
			key_q    <= req_key;
			val_q    <= req_value;
			addr_q   <= req_key[SLOT_BITS-1:0];
			found_q  <= '0;
			status_q <= lphm_pkg::ST_ZERO;
		end else if (state_q == S_CHECK) begin
			addr_q <= next_addr;
			if (hit_match) begin
				if (op_q == lphm_pkg::OP_INSERT) begin
					status_q <= lphm_pkg::ST_PRESENT;
				end else begin
					status_q <= lphm_pkg::ST_FOUND;
					found_q  <= rval;
				end
			end else if (hit_empty) begin
				status_q <= (op_q == lphm_pkg::OP_INSERT) ? lphm_pkg::ST_INSERTED
					: lphm_pkg::ST_MISSING;
			end else if (last_probe) begin
				status_q <= (op_q == lphm_pkg::OP_INSERT) ? lphm_pkg::ST_FULL
					: lphm_pkg::ST_MISSING;
			end
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.found_value = found_q;
	assign res.fill_count  = (CMP_W'(cnt_q) > CMP_W'(lphm_pkg::FILL_MAX)) ? lphm_pkg::FILL_MAX
		: lphm_pkg::FILL_W'(cnt_q);

endmodule

@@ src/linear_probe_hash_map_core.sv @@
// Linear probing hash map over 2^SLOT_BITS slots: probe sequencer, slot store, response register.
// A zero key is answered without probing; the probe loop checks one slot per cycle.
// A new request is taken only after the previous result has left the probe sequencer.
// Reset: arst_n clears control; a sweep over all 2^SLOT_BITS slots (8192 at default) then empties
// the key store, with req.ready low until it ends.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module linear_probe_hash_map_core #(
	parameter int SLOT_BITS = lphm_pkg::SLOT_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	lphm_req_if.sink          req,
	lphm_rsp_if.source        rsp
);

	lphm_pkg::mem_ctl_t         mem_ctl;
	logic [SLOT_BITS-1:0]       waddr;
	logic [SLOT_BITS-1:0]       raddr;
	logic [lphm_pkg::KEY_W-1:0] wkey;
	logic [lphm_pkg::VAL_W-1:0] wval;
	logic [lphm_pkg::KEY_W-1:0] rkey;
	logic [lphm_pkg::VAL_W-1:0] rval;
	logic                       res_valid;
	logic                       res_take;
	lphm_pkg::res_t             res;
	lphm_pkg::res_t             out_q;
	logic                       out_valid_q;

	lphm_probe_fsm #(.SLOT_BITS(SLOT_BITS)) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_op    (req.op),
		.req_key   (req.key),
		.req_value (req.value),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_ctl   (mem_ctl),
		.waddr     (waddr),
		.raddr     (raddr),
		.wkey      (wkey),
		.wval      (wval),
		.rkey      (rkey),
		.rval      (rval)
	);

	lphm_slot_mem #(.SLOT_BITS(SLOT_BITS)) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.raddr (raddr),
		.wkey  (wkey),
		.wval  (wval),
		.rkey  (rkey),
		.rval  (rval)
	);

	// output register: a waiting word does not hold up the next request
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.found_value = out_q.found_value;
	assign rsp.fill_count  = out_q.fill_count;

	`LPHM_ASSERT_NEXT(a_zero_key_fast, req.valid && req.ready && (req.key == '0), res_valid && (res.status == lphm_pkg::ST_ZERO))
	`LPHM_ASSERT_NOW(a_value_only_on_hit, rsp.valid && (rsp.status != lphm_pkg::ST_FOUND), rsp.found_value == '0)
	`LPHM_ASSERT_NOW(a_insert_counts, res_valid && (res.status == lphm_pkg::ST_INSERTED), res.fill_count != '0)
	`LPHM_ASSERT_NOW(a_no_insert_write_busy, mem_ctl.val_we, !req.ready && !res_valid)

endmodule

@@ tb/linear_probe_hash_map_core_test.sv @@
// Self-checking bench for linear_probe_hash_map_core: insert/lookup traffic with gaps and stalls.
// Depends on lphm_pkg, lphm_req_if/lphm_rsp_if and the core; a class tracks the slot store.
`timescale 1ns / 1ps

module linear_probe_hash_map_core_test;
	import lphm_pkg::*;

	localparam int SLOT_BITS       = SLOT_BITS_DEF;
	localparam int NSLOTS          = 1 << SLOT_BITS;
	localparam int RANDOM_WORDS    = 2000;
	localparam int RSP_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT  = 4 * (NSLOTS + 2) + 4000;

	class map_scoreboard;
		logic [KEY_W-1:0] slot_key [NSLOTS];
		logic [VAL_W-1:0] slot_val [NSLOTS];
		int unsigned      occupied;
		res_t             outstanding_rsp [$];
		int               requests;
		int               checked;
		int               errors;
		int               status_seen [6];

		function new();
			foreach (slot_key[i]) begin
				slot_key[i] = '0;
				slot_val[i] = '0;
			end
			occupied = 0;
		endfunction

		// match or first empty slot from the home slot, -1 when every slot holds another key
		function int probe_slot(logic [KEY_W-1:0] key);
			int idx;
			idx = key[SLOT_BITS-1:0];
			for (int n = 0; n < NSLOTS; n++) begin
				if (slot_key[idx] == '0 || slot_key[idx] == key)
					return idx;
				idx = (idx + 1) % NSLOTS;
			end
			return -1;
		endfunction

		function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
			res_t want;
			int   slot;
			want.found_value = '0;
			requests++;
			if (key == '0) begin
				want.status = ST_ZERO;
			end else begin
				slot = probe_slot(key);
				if (op == OP_INSERT) begin
					if (slot < 0) begin
						want.status = ST_FULL;
					end else if (slot_key[slot] == key) begin
						want.status = ST_PRESENT;
					end else begin
						slot_key[slot] = key;
						slot_val[slot] = value;
						occupied++;
						want.status = ST_INSERTED;
					end
				end else if (slot >= 0 && slot_key[slot] == key) begin
					want.status = ST_FOUND;
					want.found_value = slot_val[slot];
				end else begin
					want.status = ST_MISSING;
				end
			end
			want.fill_count = (occupied > FILL_MAX) ? FILL_MAX : FILL_W'(occupied);
			status_seen[want.status]++;
			outstanding_rsp.push_back(want);
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		task check_response(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] found_value,
				logic [FILL_W-1:0] fill_count);
			res_t want;
			if (outstanding_rsp.size() == 0) begin
				report("response word with no request outstanding");
				return;
			end
			want = outstanding_rsp.pop_front();
			checked++;
			if (status !== want.status)
				report($sformatf("word %0d: status %0d, expected %0d",
					checked, status, want.status));
			if (found_value !== want.found_value)
				report($sformatf("word %0d: found_value 0x%02h, expected 0x%02h",
					checked, found_value, want.found_value));
			if (fill_count !== want.fill_count)
				report($sformatf("word %0d: fill_count %0d, expected %0d",
					checked, fill_count, want.fill_count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lphm_req_if req_if();
	lphm_rsp_if rsp_if();

	linear_probe_hash_map_core #(
		.SLOT_BITS(SLOT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	map_scoreboard    sb = new();
	logic [KEY_W-1:0] stored_keys [$];
	int               send_idle_pct;
	int               rsp_stall_pct;
	int               hold_requests;
	int               quiet_cycles;
	int               send_pct_by_phase [4] = '{0, 87, 0, 6};
	int               rsp_pct_by_phase [4]  = '{0, 0, 87, 6};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.key   <= key;
		req_if.value <= value;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		sb.note_request(op, key, value);
		if (op == OP_INSERT && key != '0)
			stored_keys.push_back(key);
	endtask

	// mostly known keys, some crowded around the table end to force long wrapping probes
	task automatic run_random(int count);
		logic [KEY_W-1:0] key;
		int               r;
		int               home;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 3) begin
				key = '0;
			end else if (r < 60 && stored_keys.size() > 0) begin
				key = stored_keys[$urandom_range(stored_keys.size() - 1)];
			end else if (r < 72) begin
				key = $urandom;
				home = (NSLOTS - 8 + $urandom_range(15)) % NSLOTS;
				key[SLOT_BITS-1:0] = home[SLOT_BITS-1:0];
			end else begin
				key = $urandom;
			end
			send_word($urandom_range(1) ? OP_LOOKUP : OP_INSERT, key, VAL_W'($urandom));
		end
	endtask

	// response side: check, then pick ready for the next edge
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				sb.check_response(rsp_if.status, rsp_if.found_value, rsp_if.fill_count);
			if (hold_requests != holds_done) begin
				hold_left = RSP_HOLD_CYCLES;
				holds_done = hold_requests;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no handshake for %0d cycles, %0d words outstanding",
				$time, quiet_cycles, sb.outstanding_rsp.size());
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		quiet_cycles = 0;
		hold_requests = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		req_if.valid = 1'b0;
		req_if.op = OP_INSERT;
		req_if.key = '0;
		req_if.value = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero key, wrap at the table end, duplicates, misses inside a cluster
		send_word(OP_INSERT, 32'h0000_0000, 8'hAA);
		send_word(OP_LOOKUP, 32'h0000_0000, 8'h00);
		send_word(OP_INSERT, 32'hFFFF_FFFF, 8'hFF);
		send_word(OP_INSERT, 32'h0000_1FFF, 8'h00);
		send_word(OP_INSERT, 32'h0000_3FFF, 8'h5A);
		send_word(OP_INSERT, 32'h0000_1FFF, 8'h77);
		send_word(OP_LOOKUP, 32'h0000_3FFF, 8'h00);
		send_word(OP_LOOKUP, 32'h0000_1FFF, 8'hFF);
		send_word(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00);
		send_word(OP_LOOKUP, 32'h0000_5FFF, 8'h00);
		send_word(OP_INSERT, 32'h0000_0001, 8'h01);
		send_word(OP_LOOKUP, 32'h0000_0001, 8'h00);
		send_word(OP_INSERT, 32'h8000_0000, 8'h80);
		send_word(OP_LOOKUP, 32'h8000_0000, 8'h00);
		send_word(OP_LOOKUP, 32'h7FFF_FFFF, 8'h00);
		send_word(OP_INSERT, 32'hDEAD_BEEF, 8'hC3);
		send_word(OP_LOOKUP, 32'h1234_5678, 8'h00);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = send_pct_by_phase[phase];
			rsp_stall_pct = rsp_pct_by_phase[phase];
			// long output hold-off while words keep coming, so the core backs up
			if (phase == 0)
				hold_requests++;
			run_random(RANDOM_WORDS / 4);
		end

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		// fresh insert, likely miss, hit on the oldest key, duplicate of the newest, zero key
		send_word(OP_INSERT, $urandom | 32'h1, 8'h3C);
		send_word(OP_LOOKUP, $urandom | 32'h1, 8'h00);
		send_word(OP_LOOKUP, stored_keys[0], 8'h00);
		send_word(OP_INSERT, stored_keys[stored_keys.size() - 1], 8'hE1);
		send_word(OP_LOOKUP, 32'h0000_0000, 8'h00);
		req_if.valid <= 1'b0;

		while (sb.outstanding_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests into a %0d-slot map, fill %0d: %0d new, %0d dup, %0d dropped",
			sb.requests, NSLOTS, sb.occupied, sb.status_seen[ST_INSERTED],
			sb.status_seen[ST_PRESENT], sb.status_seen[ST_FULL]);
		$display("Lookups: %0d hit, %0d missed; %0d zero keys; %0d checked, %0d mismatches",
			sb.status_seen[ST_FOUND], sb.status_seen[ST_MISSING], sb.status_seen[ST_ZERO],
			sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
